// ===== hdl/deqgc_pkg.sv =====
// Shared types and constants of the dynamic EQ gain computer.
`default_nettype none

package deqgc_pkg;

  typedef struct packed {
    logic        [15:0] attack_coeff;
    logic        [15:0] release_coeff;
    logic signed [16:0] threshold_db;
    logic signed [14:0] range_db;
  } cfg_t;

  localparam logic [1:0] REG_ATTACK    = 2'd0;
  localparam logic [1:0] REG_RELEASE   = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;
  localparam logic [1:0] REG_RANGE     = 2'd3;

  localparam logic signed [16:0] THRESHOLD_RESET = -17'sd5120;

  localparam int          MANT_W        = 31;
  localparam int          FRAC_BITS     = 16;
  localparam int          LVL_W         = 24;
  localparam int          T_W           = 20;
  localparam int          OVER_W        = 28;
  localparam int          KNEE_PROD_W   = 36;
  localparam logic [18:0] DB_PER_OCTAVE = 19'd394566;
  localparam logic [23:0] FLOOR_DB      = 24'd10485760;
  localparam logic [19:0] HALF_KNEE     = 20'd393216;
  localparam logic [19:0] KNEE          = 20'd786432;
  localparam logic [15:0] RECIP3        = 16'd43691;
  localparam logic [15:0] DB_ROUND      = 16'd32768;
  localparam logic [14:0] BYPASS_MIN    = 15'd3;

endpackage

`default_nettype wire

// ===== hdl/deqgc_front.sv =====
// Front end: rectifies and aligns each sample and flags bypass items.
`default_nettype none

module deqgc_front #(
  parameter int SAMPLE_BITS = 24,
  parameter int ENV_BITS    = 32
) (
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  input  wire deqgc_pkg::cfg_t               cfg,
  output logic                               push,
  output logic                               push_bypass,
  output logic [ENV_BITS-1:0]                push_mag,
  input  wire logic                          q_full
);

  logic [SAMPLE_BITS-1:0]          mag;
  logic [SAMPLE_BITS+ENV_BITS-1:0] wide;
  logic [14:0]                     rmag;

  assign mag  = sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample) : SAMPLE_BITS'(sample);
  assign wide = {mag, {ENV_BITS{1'b0}}};
  assign rmag = cfg.range_db[14] ? 15'(-cfg.range_db) : 15'(cfg.range_db);

  assign push_mag    = wide[SAMPLE_BITS +: ENV_BITS];
  assign push_bypass = rmag < deqgc_pkg::BYPASS_MIN;
  assign push        = in_valid && !q_full;
  assign in_stall    = q_full;

endmodule

`default_nettype wire

// ===== hdl/deqgc_queue.sv =====
// Small FIFO between the front end and the gain sequencer.
`default_nettype none

module deqgc_queue #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  pop_valid,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full      = count == CW'(DEPTH);
  assign pop_valid = count != '0;
  assign pop_data  = mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/deqgc_back.sv =====
// Gain sequencer: envelope update, log2 by squaring, dB scaling and soft knee.
`default_nettype none

module deqgc_back #(
  parameter int ENV_BITS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire deqgc_pkg::cfg_t     cfg,
  input  wire logic                q_valid,
  input  wire logic                q_bypass,
  input  wire logic [ENV_BITS-1:0] q_mag,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [14:0]       gain_db
);

  localparam int ZW    = $clog2(ENV_BITS);
  localparam int NEG_W = ZW + deqgc_pkg::FRAC_BITS;
  localparam int P_W   = NEG_W + 19;
  localparam int MW    = deqgc_pkg::MANT_W;
  localparam int OW    = deqgc_pkg::OVER_W;
  localparam logic [ZW-1:0]       STEP_START = ZW'(1) << (ZW - 1);
  localparam logic [ENV_BITS-1:0] ENV_FULL   = {1'b1, {(ENV_BITS-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_ENV, S_PREP, S_NORM, S_MANT, S_LOG, S_DB, S_CLIP, S_OVER, S_KNEE, S_OUT
  } state_t;

  state_t                         state;
  logic                           byp;
  logic [ENV_BITS-1:0]            a;
  logic [ENV_BITS-1:0]            env;
  logic [ENV_BITS-1:0]            norm;
  logic [ZW-1:0]                  zcnt;
  logic [ZW-1:0]                  step;
  logic [MW-1:0]                  m;
  logic [deqgc_pkg::FRAC_BITS-1:0] frac;
  logic [3:0]                     cnt;
  logic [P_W-1:0]                 prod;
  logic [deqgc_pkg::LVL_W-1:0]    lvl_mag;
  logic [deqgc_pkg::T_W-1:0]      t;
  logic [15:0]                    y;

  logic                           rise;
  logic [ENV_BITS-1:0]            diff;
  logic [15:0]                    coeff;
  logic [ENV_BITS+15:0]           env_prod;
  logic [ENV_BITS-1:0]            env_step;
  logic [ENV_BITS-1:0]            env_next;
  logic [ENV_BITS-1:0]            hi_mask;
  logic                           top_zero;
  logic [ENV_BITS+MW-1:0]         normx;
  logic [2*MW-1:0]                sq;
  logic [NEG_W-1:0]               neg;
  logic [P_W:0]                   rnd;
  logic [P_W-16:0]                dbm;
  logic signed [OW-1:0]           thr256;
  logic signed [OW-1:0]           tt;
  logic [14:0]                    rmag;
  logic                           rneg;
  logic [deqgc_pkg::KNEE_PROD_W-1:0] kx;
  logic [31:0]                    dq;
  logic [14:0]                    q;
  logic [14:0]                    res;
  logic                           load_out;

  assign rise     = a > env;
  assign diff     = rise ? a - env : env - a;
  assign coeff    = rise ? cfg.attack_coeff : cfg.release_coeff;
  assign env_prod = (ENV_BITS+16)'(diff) * (ENV_BITS+16)'(coeff);
  assign env_step = env_prod[ENV_BITS+15:16];
  assign env_next = rise ? a - env_step : a + env_step;

  assign hi_mask  = ~({ENV_BITS{1'b1}} >> step);
  assign top_zero = (norm & hi_mask) == '0;
  assign normx    = {norm, {MW{1'b0}}};
  assign sq       = {{MW{1'b0}}, m} * {{MW{1'b0}}, m};

  assign neg    = {zcnt, {deqgc_pkg::FRAC_BITS{1'b0}}} - NEG_W'(frac);
  assign rnd    = {1'b0, prod} + (P_W+1)'(deqgc_pkg::DB_ROUND);
  assign dbm    = rnd[P_W:16];

  assign thr256 = {{(OW-25){cfg.threshold_db[16]}}, cfg.threshold_db, 8'b0};
  assign tt     = -$signed({{(OW-deqgc_pkg::LVL_W){1'b0}}, lvl_mag}) - thr256
                  + $signed({{(OW-deqgc_pkg::T_W){1'b0}}, deqgc_pkg::HALF_KNEE});

  assign rneg   = cfg.range_db[14];
  assign rmag   = rneg ? 15'(-cfg.range_db) : 15'(cfg.range_db);
  assign kx     = deqgc_pkg::KNEE_PROD_W'(rmag) * deqgc_pkg::KNEE_PROD_W'(t)
                  + deqgc_pkg::KNEE_PROD_W'(deqgc_pkg::HALF_KNEE);
  assign dq     = 32'(y) * 32'(deqgc_pkg::RECIP3);
  assign q      = dq[31:17];
  assign res    = rneg ? 15'(-q) : q;

  assign q_pop    = (state == S_IDLE) && q_valid;
  assign load_out = (state == S_OUT) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      env       <= '0;
      byp       <= 1'b0;
      cnt       <= '0;
    end else begin
      if (out_valid && !out_stall && !load_out) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            a   <= q_mag;
            byp <= q_bypass;
            if (q_bypass) begin
              t     <= '0;
              state <= S_KNEE;
            end else begin
              state <= S_ENV;
            end
          end
        end
        S_ENV: begin
          env   <= env_next;
          state <= S_PREP;
        end
        S_PREP: begin
          norm <= env;
          zcnt <= '0;
          step <= STEP_START;
          if (env == '0) begin
            lvl_mag <= deqgc_pkg::FLOOR_DB;
            state   <= S_OVER;
          end else begin
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (top_zero) begin
            norm <= norm << step;
            zcnt <= zcnt + step;
          end
          step <= step >> 1;
          if (step == ZW'(1)) begin
            state <= S_MANT;
          end
        end
        S_MANT: begin
          m     <= normx[ENV_BITS+MW-1 -: MW];
          frac  <= '0;
          cnt   <= '0;
          state <= S_LOG;
        end
        S_LOG: begin
          frac <= {frac[deqgc_pkg::FRAC_BITS-2:0], sq[2*MW-1]};
          m    <= sq[2*MW-1] ? sq[2*MW-1:MW] : sq[2*MW-2:MW-1];
          cnt  <= cnt + 1'b1;
          if (cnt == 4'd15) begin
            state <= S_DB;
          end
        end
        S_DB: begin
          prod  <= P_W'(neg) * P_W'(deqgc_pkg::DB_PER_OCTAVE);
          state <= S_CLIP;
        end
        S_CLIP: begin
          if (dbm > (P_W-15)'(deqgc_pkg::FLOOR_DB)) begin
            lvl_mag <= deqgc_pkg::FLOOR_DB;
          end else begin
            lvl_mag <= dbm[deqgc_pkg::LVL_W-1:0];
          end
          state <= S_OVER;
        end
        S_OVER: begin
          if (tt <= 0) begin
            t <= '0;
          end else if (tt >= $signed({{(OW-deqgc_pkg::T_W){1'b0}}, deqgc_pkg::KNEE})) begin
            t <= deqgc_pkg::KNEE;
          end else begin
            t <= tt[deqgc_pkg::T_W-1:0];
          end
          state <= S_KNEE;
        end
        S_KNEE: begin
          y     <= kx[33:18];
          state <= S_OUT;
        end
        S_OUT: begin
          if (load_out) begin
            gain_db   <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_mant_norm: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOG) |-> m[MW-1])
    else $error("mantissa lost its leading one");

  a_env_full: assert property (@(posedge clk) disable iff (rst)
    env <= ENV_FULL)
    else $error("envelope above full scale");

  a_bypass_zero: assert property (@(posedge clk) disable iff (rst)
    (load_out && byp) |=> (gain_db == '0))
    else $error("bypass beat produced nonzero gain");

  a_t_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_KNEE) |-> (t <= deqgc_pkg::KNEE))
    else $error("knee position out of range");

endmodule

`default_nettype wire

// ===== hdl/dynamic_eq_gain_computer.sv =====
// Top level of the dynamic EQ gain computer: register port, front end, queue, sequencer.
// Each accepted sample yields one gain_db beat. Time in the sequencer is set by the
// sixteen squaring steps of the log2 unit plus a binary leading-one search of
// clog2(ENV_BITS) steps; a zero envelope skips both, and a bypass sample
// (|range_db| under 3 LSB) goes straight from idle to the knee step.
// A two-beat queue lets the front end take samples while the sequencer works, and
// the output register lets the next sample start while a result waits.
`default_nettype none

module dynamic_eq_gain_computer #(
  parameter int SAMPLE_BITS = 24,
  parameter int ENV_BITS    = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [3:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [14:0]                 gain_db
);

  localparam int Q_DEPTH = 2;

  deqgc_pkg::cfg_t     cfg;
  logic [1:0]          reg_idx;
  logic                wr_en;
  logic                push;
  logic                push_bypass;
  logic [ENV_BITS-1:0] push_mag;
  logic                q_full;
  logic                q_pop;
  logic                q_valid;
  logic [ENV_BITS:0]   q_data;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.attack_coeff  <= '0;
      cfg.release_coeff <= '0;
      cfg.threshold_db  <= deqgc_pkg::THRESHOLD_RESET;
      cfg.range_db      <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        deqgc_pkg::REG_ATTACK:    cfg.attack_coeff  <= pwdata[15:0];
        deqgc_pkg::REG_RELEASE:   cfg.release_coeff <= pwdata[15:0];
        deqgc_pkg::REG_THRESHOLD: cfg.threshold_db  <= $signed(pwdata[16:0]);
        deqgc_pkg::REG_RANGE:     cfg.range_db      <= $signed(pwdata[14:0]);
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      deqgc_pkg::REG_ATTACK:    prdata = {16'b0, cfg.attack_coeff};
      deqgc_pkg::REG_RELEASE:   prdata = {16'b0, cfg.release_coeff};
      deqgc_pkg::REG_THRESHOLD: prdata = {15'b0, cfg.threshold_db};
      deqgc_pkg::REG_RANGE:     prdata = {17'b0, cfg.range_db};
      default:                  prdata = '0;
    endcase
  end

  deqgc_front #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .ENV_BITS   (ENV_BITS)
  ) u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample     (sample),
    .cfg        (cfg),
    .push       (push),
    .push_bypass(push_bypass),
    .push_mag   (push_mag),
    .q_full     (q_full)
  );

  deqgc_queue #(
    .WIDTH(ENV_BITS + 1),
    .DEPTH(Q_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data({push_bypass, push_mag}),
    .full     (q_full),
    .pop      (q_pop),
    .pop_valid(q_valid),
    .pop_data (q_data)
  );

  deqgc_back #(
    .ENV_BITS(ENV_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_bypass (q_data[ENV_BITS]),
    .q_mag    (q_data[ENV_BITS-1:0]),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .gain_db  (gain_db)
  );

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for dynamic_eq_gain_computer: directed table, then random phases against a gain model.
module tb_top;

  localparam int     CYCLE_LIMIT   = 400000;
  localparam int     NUM_PHASES    = 10;
  localparam int     PHASE_ITEMS   = 100;
  localparam int     DRAIN_CYCLES  = 40;
  localparam longint DB_OCT_Q16    = 394566;
  localparam longint FLOOR_Q16     = -160 * 65536;
  localparam longint HALF_KNEE_Q16 = 6 * 65536;
  localparam longint KNEE_Q16      = 12 * 65536;
  localparam logic signed [23:0] SMP_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] SMP_MIN = 24'sh800000;
  localparam logic [1:0] R_ATT = deqgc_pkg::REG_ATTACK;
  localparam logic [1:0] R_REL = deqgc_pkg::REG_RELEASE;
  localparam logic [1:0] R_THR = deqgc_pkg::REG_THRESHOLD;
  localparam logic [1:0] R_RNG = deqgc_pkg::REG_RANGE;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [1:0]         idx;
    logic [31:0]        data;
    logic signed [23:0] smp;
    bit                 known;
    logic signed [14:0] gain;
  } dir_row_t;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [3:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid;
  logic                in_stall;
  logic signed [23:0]  sample;
  logic                out_valid;
  logic                out_stall;
  logic signed [14:0]  gain_db;

  deqgc_pkg::cfg_t     cfg_shadow;
  logic [31:0]         env_track;
  logic signed [14:0]  pending_gain[$];
  logic signed [14:0]  exp_gain;
  dir_row_t            dir_rows[$];
  int                  fails;
  int                  cycle_count;
  int                  stall_left;
  bit                  idle_on;

  dynamic_eq_gain_computer #(
    .SAMPLE_BITS(24),
    .ENV_BITS   (32)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sample   (sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .gain_db  (gain_db)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [14:0] predict_gain(input logic signed [23:0] smp);
    longint      rmag;
    longint      mag;
    longint      lvl;
    longint      over;
    longint      q;
    logic [63:0] a;
    logic [63:0] env;
    logic [63:0] m;
    logic [63:0] sq;
    logic [63:0] frac;
    logic [63:0] neg;
    int          p;
    int          i;
    bit          rneg;
    rneg = cfg_shadow.range_db < 0;
    rmag = rneg ? -longint'(cfg_shadow.range_db) : longint'(cfg_shadow.range_db);
    if (rmag < 3) return '0;
    mag = longint'(smp);
    if (mag < 0) mag = -mag;
    a = 64'(mag) << 8;
    env = {32'd0, env_track};
    if (a > env) begin
      env = a - (((a - env) * cfg_shadow.attack_coeff) >> 16);
    end else begin
      env = a + (((env - a) * cfg_shadow.release_coeff) >> 16);
    end
    env_track = env[31:0];
    if (env_track == 32'd0) begin
      lvl = FLOOR_Q16;
    end else begin
      p = 0;
      for (i = 0; i < 32; i++) begin
        if (env_track[i]) p = i;
      end
      if (p <= 30) m = {32'd0, env_track} << (30 - p);
      else m = {32'd0, env_track} >> (p - 30);
      frac = '0;
      for (i = 0; i < 16; i++) begin
        sq = m * m;
        frac = frac << 1;
        if (sq >= 64'h2000_0000_0000_0000) begin
          frac[0] = 1'b1;
          m = sq >> 31;
        end else begin
          m = sq >> 30;
        end
      end
      neg = (p >= 31) ? 64'd0 : (64'(31 - p) << 16) - frac;
      lvl = -longint'((neg * 64'(DB_OCT_Q16) + 64'd32768) >> 16);
    end
    if (lvl < FLOOR_Q16) lvl = FLOOR_Q16;
    over = lvl - longint'(cfg_shadow.threshold_db) * 256;
    if (over <= -HALF_KNEE_Q16) q = 0;
    else if (over >= HALF_KNEE_Q16) q = rmag;
    else q = (rmag * (over + HALF_KNEE_Q16) + KNEE_Q16 / 2) / KNEE_Q16;
    return rneg ? 15'(-q) : 15'(q);
  endfunction

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      deqgc_pkg::REG_ATTACK:    cfg_shadow.attack_coeff  = data[15:0];
      deqgc_pkg::REG_RELEASE:   cfg_shadow.release_coeff = data[15:0];
      deqgc_pkg::REG_THRESHOLD: cfg_shadow.threshold_db  = data[16:0];
      deqgc_pkg::REG_RANGE:     cfg_shadow.range_db      = data[14:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_gain.size() != 0) @(posedge clk);
  endtask

  task automatic send_sample(input logic signed [23:0] smp, input bit known,
                             input logic signed [14:0] typed);
    logic signed [14:0] g;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= smp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    g = predict_gain(smp);
    pending_gain.push_back(known ? typed : g);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_gain.size() == 0) begin
          $error("gain_db: unexpected beat, got %0d", gain_db);
          fails++;
        end else begin
          exp_gain = pending_gain.pop_front();
          if (gain_db !== exp_gain) begin
            $error("gain_db: expected %0d, got %0d", exp_gain, gain_db);
            fails++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 5);
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int                 ph;
    int                 k;
    int                 r;
    int                 mag;
    int                 amp_shift;
    int                 att;
    int                 rel;
    int                 thr;
    int                 rng;
    logic signed [23:0] smp;
    rst         <= 1'b1;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_valid    <= 1'b0;
    sample      <= '0;
    idle_on     = 1'b1;
    amp_shift   = 12;
    env_track   = '0;
    cfg_shadow  = '{attack_coeff: '0, release_coeff: '0,
                    threshold_db: deqgc_pkg::THRESHOLD_RESET, range_db: '0};
    dir_rows = '{
      '{ROW_SAMPLE, R_ATT, 32'h0,         24'sd0,       1'b1, 15'sd0},
      '{ROW_SAMPLE, R_ATT, 32'h0,         SMP_MAX,      1'b1, 15'sd0},
      '{ROW_SAMPLE, R_ATT, 32'h0,         SMP_MIN,      1'b1, 15'sd0},
      '{ROW_WRITE,  R_RNG, 32'h1234_3000, 24'sd0,       1'b0, 15'sd0},
      '{ROW_WRITE,  R_THR, 32'hABCC_1800, 24'sd0,       1'b0, 15'sd0},
      '{ROW_WRITE,  R_ATT, 32'hFFFF_0000, 24'sd0,       1'b0, 15'sd0},
      '{ROW_WRITE,  R_REL, 32'h8000_0000, 24'sd0,       1'b0, 15'sd0},
      '{ROW_SAMPLE, R_ATT, 32'h0,         SMP_MIN,      1'b1, 15'sd0},
      '{ROW_WRITE,  R_THR, 32'h5A5F_6000, 24'sd0,       1'b0, 15'sd0},
      '{ROW_SAMPLE, R_ATT, 32'h0,         SMP_MIN,      1'b1, 15'sd12288},
      '{ROW_SAMPLE, R_ATT, 32'h0,         24'sd0,       1'b1, 15'sd6144},
      '{ROW_WRITE,  R_RNG, 32'hFFFF_D000, 24'sd0,       1'b0, 15'sd0},
      '{ROW_SAMPLE, R_ATT, 32'h0,         SMP_MAX,      1'b1, -15'sd12288},
      '{ROW_SAMPLE, R_ATT, 32'h0,         24'sd0,       1'b1, -15'sd6144},
      '{ROW_WRITE,  R_RNG, 32'h0000_0002, 24'sd0,       1'b0, 15'sd0},
      '{ROW_SAMPLE, R_ATT, 32'h0,         24'sd1234567, 1'b1, 15'sd0},
      '{ROW_WRITE,  R_RNG, 32'h0000_7FFE, 24'sd0,       1'b0, 15'sd0},
      '{ROW_SAMPLE, R_ATT, 32'h0,         -24'sd1,      1'b1, 15'sd0},
      '{ROW_WRITE,  R_RNG, 32'h0000_0003, 24'sd0,       1'b0, 15'sd0},
      '{ROW_SAMPLE, R_ATT, 32'h0,         24'sd1,       1'b0, 15'sd0},
      '{ROW_WRITE,  R_RNG, 32'h0000_7FFD, 24'sd0,       1'b0, 15'sd0},
      '{ROW_SAMPLE, R_ATT, 32'h0,         -24'sd1,      1'b0, 15'sd0},
      '{ROW_WRITE,  R_RNG, 32'h0000_3000, 24'sd0,       1'b0, 15'sd0},
      '{ROW_WRITE,  R_THR, 32'h0001_EC00, 24'sd0,       1'b0, 15'sd0},
      '{ROW_WRITE,  R_ATT, 32'h0000_FFFF, 24'sd0,       1'b0, 15'sd0},
      '{ROW_WRITE,  R_REL, 32'h0000_FFFF, 24'sd0,       1'b0, 15'sd0},
      '{ROW_SAMPLE, R_ATT, 32'h0,         SMP_MAX,      1'b0, 15'sd0},
      '{ROW_SAMPLE, R_ATT, 32'h0,         SMP_MIN,      1'b0, 15'sd0},
      '{ROW_SAMPLE, R_ATT, 32'h0,         24'sd4096,    1'b0, 15'sd0},
      '{ROW_SAMPLE, R_ATT, 32'h0,         24'sd0,       1'b0, 15'sd0},
      '{ROW_WRITE,  R_ATT, 32'h0000_8000, 24'sd0,       1'b0, 15'sd0},
      '{ROW_WRITE,  R_REL, 32'h0000_FF00, 24'sd0,       1'b0, 15'sd0},
      '{ROW_SAMPLE, R_ATT, 32'h0,         24'sh400000,  1'b0, 15'sd0},
      '{ROW_SAMPLE, R_ATT, 32'h0,         -24'sd256,    1'b0, 15'sd0},
      '{ROW_SAMPLE, R_ATT, 32'h0,         SMP_MAX,      1'b0, 15'sd0},
      '{ROW_SAMPLE, R_ATT, 32'h0,         24'sd0,       1'b0, 15'sd0}
    };
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        hold_until_drained();
        reg_write(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_sample(dir_rows[i].smp, dir_rows[i].known, dir_rows[i].gain);
      end
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      idle_on = (ph != NUM_PHASES - 1) && (ph % 3 != 1);
      case (ph)
        0: begin
          att = 0;
          rel = 0;
        end
        1: begin
          att = 65535;
          rel = 65535;
        end
        default: begin
          att = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                            : $urandom_range(60000, 65535);
          rel = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                            : $urandom_range(60000, 65535);
        end
      endcase
      r = $urandom_range(0, 7);
      if (r == 0) thr = -40960;
      else if (r == 1) thr = 6144;
      else if (r < 5) thr = $urandom_range(0, 15360) - 15360;
      else thr = $urandom_range(0, 47104) - 40960;
      r = $urandom_range(0, 7);
      if (r == 0) rng = 12288;
      else if (r == 1) rng = -12288;
      else if (r == 2) rng = $urandom_range(0, 4) - 2;
      else rng = $urandom_range(0, 24576) - 12288;
      hold_until_drained();
      reg_write(deqgc_pkg::REG_ATTACK,    {16'($urandom), 16'(att)});
      reg_write(deqgc_pkg::REG_RELEASE,   {16'($urandom), 16'(rel)});
      reg_write(deqgc_pkg::REG_THRESHOLD, {15'($urandom), 17'(thr)});
      reg_write(deqgc_pkg::REG_RANGE,     {17'($urandom), 15'(rng)});
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 4 && k == PHASE_ITEMS / 2) hold_until_drained();
        if ($urandom_range(0, 15) == 0) amp_shift = $urandom_range(0, 23);
        r = $urandom_range(0, 19);
        if (r < 12) begin
          mag = $urandom_range(0, (1 << amp_shift) - 1);
          smp = $urandom_range(0, 1) ? 24'(-mag) : 24'(mag);
        end else if (r < 15) begin
          smp = 24'($urandom);
        end else if (r < 17) begin
          smp = '0;
        end else begin
          case ($urandom_range(0, 3))
            0: smp = SMP_MAX;
            1: smp = SMP_MIN;
            2: smp = 24'sd1;
            default: smp = -24'sd1;
          endcase
        end
        send_sample(smp, 1'b0, 15'sd0);
      end
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
